// File: sv/rtlu_pkg.sv
// Shared types and constants for the range-table route lookup engine.
`default_nettype none

package rtlu_pkg;

    localparam int KICK_BITS_DEF     = 14;
    localparam int RANGE_ENTRIES_DEF = 65536;

    localparam int ADDR_W = 32;
    localparam int IDX_W  = 16;
    localparam int PORT_W = 9;
    localparam int HOP_W  = PORT_W + ADDR_W;
    // Search bounds reach base + last, which needs one bit more than an index.
    localparam int SPAN_W = IDX_W + 1;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_KICK   = 2'd1,
        KIND_RANGE  = 2'd2,
        KIND_HOP    = 2'd3
    } t_kind;

    typedef struct packed {
        logic clear;
        logic load;
        logic wr_kick;
        logic wr_range;
        logic wr_hop;
        logic init;
        logic probe;
        logic step;
        logic fin;
        logic hop;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic open;
        logic hit;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: sv/rtlu_ctrl.sv
// Controller state machine of the route lookup engine.
`default_nettype none

module rtlu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  rtlu_pkg::t_kind       i_kind,
    input  rtlu_pkg::t_dp_sts     i_sts,
    output rtlu_pkg::t_dp_cmd     o_cmd,
    output logic                  busy,
    output logic                  o_valid
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_KICK  = 8'b0000_0100,
        ST_LOOP  = 8'b0000_1000,
        ST_CMP   = 8'b0001_0000,
        ST_FIN   = 8'b0010_0000,
        ST_HOP   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (i_kind)
                        rtlu_pkg::KIND_LOOKUP: begin
                            o_cmd.load = 1'b1;
                            n_state    = ST_KICK;
                        end
                        rtlu_pkg::KIND_KICK:  o_cmd.wr_kick  = 1'b1;
                        rtlu_pkg::KIND_RANGE: o_cmd.wr_range = 1'b1;
                        rtlu_pkg::KIND_HOP:   o_cmd.wr_hop   = 1'b1;
                        default:              n_state        = ST_IDLE;
                    endcase
                end
            end
            ST_KICK: begin
                o_cmd.init = 1'b1;
                n_state    = ST_LOOP;
            end
            ST_LOOP: begin
                if (i_sts.open) begin
                    o_cmd.probe = 1'b1;
                    n_state     = ST_CMP;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_HOP;
                end
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.hit ? ST_FIN : ST_LOOP;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_HOP;
            end
            ST_HOP: begin
                o_cmd.hop = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

endmodule

`default_nettype wire

// File: sv/rtlu_dp.sv
// Datapath of the route lookup engine: table memories, search bounds and clear counter.
`default_nettype none

module rtlu_dp #(
    parameter int KICK_BITS     = rtlu_pkg::KICK_BITS_DEF,
    parameter int RANGE_ENTRIES = rtlu_pkg::RANGE_ENTRIES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  rtlu_pkg::t_dp_cmd                        i_cmd,
    output rtlu_pkg::t_dp_sts                        o_sts,
    input  wire logic [rtlu_pkg::ADDR_W-1:0]         i_dest_addr,
    input  wire logic [rtlu_pkg::IDX_W-1:0]          i_entry_index,
    input  wire logic [rtlu_pkg::IDX_W-1:0]          i_block_base,
    input  wire logic [rtlu_pkg::IDX_W-1:0]          i_block_last,
    input  wire logic [rtlu_pkg::ADDR_W-1:0]         i_range_word,
    input  wire logic signed [rtlu_pkg::PORT_W-1:0]  i_hop_port,
    input  wire logic [rtlu_pkg::ADDR_W-1:0]         i_hop_gateway,
    output logic signed [rtlu_pkg::PORT_W-1:0]       o_out_port,
    output logic [rtlu_pkg::ADDR_W-1:0]              o_out_gateway,
    output logic [rtlu_pkg::IDX_W-1:0]               o_matched_range
);

    localparam int ADDR_W     = rtlu_pkg::ADDR_W;
    localparam int IDX_W      = rtlu_pkg::IDX_W;
    localparam int SPAN_W     = rtlu_pkg::SPAN_W;
    localparam int HOP_W      = rtlu_pkg::HOP_W;
    localparam int KICK_DEPTH = 1 << KICK_BITS;
    localparam int LOW_W      = ADDR_W - KICK_BITS;
    localparam int RIW        = $clog2(RANGE_ENTRIES);
    localparam int CLR_DEPTH  = (RANGE_ENTRIES > KICK_DEPTH) ? RANGE_ENTRIES : KICK_DEPTH;
    localparam int CW         = $clog2(CLR_DEPTH);
    localparam int FOLD_FLOOR = $clog2(RANGE_ENTRIES + 1) - 1;
    localparam int FOLD_STEPS = (SPAN_W > FOLD_FLOOR) ? SPAN_W - FOLD_FLOOR : 0;
    localparam int FW         = ((SPAN_W > RIW) ? SPAN_W : RIW) + 1;

    // Reduces a search index modulo the range table depth by restoring subtraction
    // of shifted copies of the depth; a power-of-two depth collapses to a mask.
    function automatic logic [RIW-1:0] fold(input logic [SPAN_W-1:0] v);
        logic [FW-1:0] t;
        logic [FW-1:0] m;
        t = FW'(v);
        for (int k = FOLD_STEPS - 1; k >= 0; k--) begin
            m = FW'(RANGE_ENTRIES) << k;
            if (t >= m) begin
                t = t - m;
            end
        end
        return t[RIW-1:0];
    endfunction

    logic [IDX_W-1:0]  kick_base_mem [KICK_DEPTH];
    logic [IDX_W-1:0]  kick_last_mem [KICK_DEPTH];
    logic [ADDR_W-1:0] range_mem     [RANGE_ENTRIES];
    logic [HOP_W-1:0]  hop_mem       [KICK_DEPTH];

    logic [CW-1:0]     r_clr;
    logic [LOW_W-1:0]  r_key;
    logic [SPAN_W-1:0] r_lo;
    logic [SPAN_W-1:0] r_hi;
    logic [SPAN_W-1:0] r_mid;
    logic [RIW-1:0]    r_fin;
    logic [IDX_W-1:0]  r_base_rd;
    logic [IDX_W-1:0]  r_last_rd;
    logic [ADDR_W-1:0] r_rng_a_rd;
    logic [ADDR_W-1:0] r_rng_b_rd;
    logic [HOP_W-1:0]  r_hop_rd;

    logic [SPAN_W:0]         mid_sum;
    logic [SPAN_W-1:0]       mid;
    logic [SPAN_W-1:0]       mid_next;
    logic [RIW-1:0]          rng_a_addr;
    logic [RIW-1:0]          rng_b_addr;
    logic [KICK_BITS-1:0]    kick_wa;
    logic [IDX_W-1:0]        kick_base_wd;
    logic [IDX_W-1:0]        kick_last_wd;
    logic                    kick_we;
    logic [RIW-1:0]          range_wa;
    logic [ADDR_W-1:0]       range_wd;
    logic                    range_we;
    logic [HOP_W-1:0]        hop_wd;
    logic                    hop_we;
    logic                    clr_in_range;
    logic                    key_lt_mid;
    logic                    key_lt_next;
    logic [KICK_BITS-1:0]    kick_ra;
    logic [KICK_BITS-1:0]    hop_ra;

    assign mid_sum  = (SPAN_W + 1)'(r_hi) + (SPAN_W + 1)'(r_lo);
    assign mid      = mid_sum[SPAN_W:1];
    assign mid_next = mid + SPAN_W'(1);

    assign rng_a_addr = i_cmd.fin ? fold(r_lo) : fold(mid);
    assign rng_b_addr = fold(mid_next);

    assign kick_ra = i_dest_addr[ADDR_W-1 -: KICK_BITS];
    assign hop_ra  = r_rng_a_rd[ADDR_W-1 -: KICK_BITS];

    assign clr_in_range = ({1'b0, r_clr} < (CW + 1)'(RANGE_ENTRIES));

    always_comb begin
        kick_we      = i_cmd.clear || i_cmd.wr_kick;
        kick_wa      = i_cmd.clear ? r_clr[KICK_BITS-1:0] : i_entry_index[KICK_BITS-1:0];
        kick_base_wd = i_cmd.clear ? '0 : i_block_base;
        kick_last_wd = i_cmd.clear ? '0 : i_block_last;

        range_we = (i_cmd.clear && clr_in_range) || i_cmd.wr_range;
        range_wa = i_cmd.clear ? r_clr[RIW-1:0] : fold(SPAN_W'(i_entry_index));
        range_wd = i_cmd.clear ? '0 : i_range_word;

        hop_we = i_cmd.clear || i_cmd.wr_hop;
        hop_wd = i_cmd.clear ? '0 : {i_hop_port, i_hop_gateway};
    end

    always_ff @(posedge i_clk) begin
        if (kick_we) begin
            kick_base_mem[kick_wa] <= kick_base_wd;
            kick_last_mem[kick_wa] <= kick_last_wd;
        end
        if (i_cmd.load) begin
            r_base_rd <= kick_base_mem[kick_ra];
            r_last_rd <= kick_last_mem[kick_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (range_we) begin
            range_mem[range_wa] <= range_wd;
        end
        if (i_cmd.probe || i_cmd.fin) begin
            r_rng_a_rd <= range_mem[rng_a_addr];
        end
        if (i_cmd.probe) begin
            r_rng_b_rd <= range_mem[rng_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hop_we) begin
            hop_mem[kick_wa] <= hop_wd;
        end
        if (i_cmd.hop) begin
            r_hop_rd <= hop_mem[hop_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + CW'(1);
        end
    end

    assign key_lt_mid  = (r_key < r_rng_a_rd[LOW_W-1:0]);
    assign key_lt_next = (r_key < r_rng_b_rd[LOW_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_dest_addr[LOW_W-1:0];
        end
        if (i_cmd.init) begin
            r_lo <= SPAN_W'(r_base_rd);
            r_hi <= SPAN_W'(r_base_rd) + SPAN_W'(r_last_rd);
        end else if (i_cmd.step) begin
            if (key_lt_mid) begin
                r_hi <= r_mid;
            end else if (key_lt_next) begin
                r_lo <= r_mid;
            end else begin
                r_lo <= r_mid + SPAN_W'(1);
            end
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.fin) begin
            r_fin <= fold(r_lo);
        end
    end

    assign o_sts.clear_last = (r_clr == CW'(CLR_DEPTH - 1));
    assign o_sts.open       = (r_hi > r_lo);
    assign o_sts.hit        = !key_lt_mid && key_lt_next;

    assign o_out_port      = $signed(r_hop_rd[HOP_W-1:ADDR_W]);
    assign o_out_gateway   = r_hop_rd[ADDR_W-1:0];
    assign o_matched_range = IDX_W'(r_fin);

endmodule

`default_nettype wire

// File: sv/range_table_ip_route_lookup.sv
// Top level of the range-table IPv4 route lookup engine.
//
//  Channel   Handshake            Payload
//  request   start / busy         i_kind, i_dest_addr, i_entry_index, i_block_base,
//                                 i_block_last, i_range_word, i_hop_port, i_hop_gateway
//  result    o_valid (strobe)     o_out_port, o_out_gateway, o_matched_range
//
// A write request leaves busy low. In a lookup request each binary-search level
// passes through an address state and a compare state around the registered
// range-table read. After reset the engine clears all tables, one entry per
// cycle, with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module range_table_ip_route_lookup #(
    parameter int KICK_BITS     = rtlu_pkg::KICK_BITS_DEF,
    parameter int RANGE_ENTRIES = rtlu_pkg::RANGE_ENTRIES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_kind,
    input  wire logic [rtlu_pkg::ADDR_W-1:0]         i_dest_addr,
    input  wire logic [rtlu_pkg::IDX_W-1:0]          i_entry_index,
    input  wire logic [rtlu_pkg::IDX_W-1:0]          i_block_base,
    input  wire logic [rtlu_pkg::IDX_W-1:0]          i_block_last,
    input  wire logic [rtlu_pkg::ADDR_W-1:0]         i_range_word,
    input  wire logic signed [rtlu_pkg::PORT_W-1:0]  i_hop_port,
    input  wire logic [rtlu_pkg::ADDR_W-1:0]         i_hop_gateway,
    output logic                                     o_valid,
    output logic signed [rtlu_pkg::PORT_W-1:0]       o_out_port,
    output logic [rtlu_pkg::ADDR_W-1:0]              o_out_gateway,
    output logic [rtlu_pkg::IDX_W-1:0]               o_matched_range
);

    rtlu_pkg::t_dp_cmd dp_cmd;
    rtlu_pkg::t_dp_sts dp_sts;
    rtlu_pkg::t_kind   kind;

    assign kind = rtlu_pkg::t_kind'(i_kind);

    rtlu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (kind),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    rtlu_dp #(
        .KICK_BITS     (KICK_BITS),
        .RANGE_ENTRIES (RANGE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_dest_addr     (i_dest_addr),
        .i_entry_index   (i_entry_index),
        .i_block_base    (i_block_base),
        .i_block_last    (i_block_last),
        .i_range_word    (i_range_word),
        .i_hop_port      (i_hop_port),
        .i_hop_gateway   (i_hop_gateway),
        .o_out_port      (o_out_port),
        .o_out_gateway   (o_out_gateway),
        .o_matched_range (o_matched_range)
    );

    // A result only appears while the engine is still marked busy.
    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while engine idle");

    // A lookup request always occupies the engine in the following cycle.
    a_lookup_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (kind == rtlu_pkg::KIND_LOOKUP)) |=> busy)
        else $error("lookup request did not occupy the engine");

    // A table write completes at once and produces no result.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (kind != rtlu_pkg::KIND_LOOKUP)) |=> (!busy && !o_valid))
        else $error("table write left the engine busy or gave a result");

    // The engine is free again right after delivering a result.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("engine not free after result");

endmodule

`default_nettype wire
